### rtl/core/whp_pkg.sv
`default_nettype none

package whp_pkg;

    // Fixed field widths
    localparam int BYTE_W     = 8;
    localparam int WORD_W     = 32;
    localparam int HALF_W     = 16;
    localparam int FRAME_W    = 30;
    localparam int POS_W      = 5;
    localparam int DIV_CNT_W  = $clog2(FRAME_W);
    localparam int ALIGN_W    = 4;

    // Data chunk length limit in bytes; lengths at or above it are refused
    localparam logic [WORD_W-1:0] MAX_DATA_BYTES = 32'h4000_0000;

    localparam logic [HALF_W-1:0] SKIP_LIMIT_RST = 16'd1000;
    localparam logic [WORD_W-1:0] PCM_FMT_LEN    = 32'd16;

    // Chunk ids, little endian as they shift in
    localparam logic [WORD_W-1:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [WORD_W-1:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [WORD_W-1:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [WORD_W-1:0] TAG_DATA = 32'h6174_6164;

    // Result kinds
    localparam logic [1:0] KIND_REPORT  = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    // Sample kinds
    localparam logic [1:0] SMP_UNSIGNED = 2'd0;
    localparam logic [1:0] SMP_SIGNED   = 2'd1;
    localparam logic [1:0] SMP_FLOAT    = 2'd2;

    // Error codes
    localparam logic [2:0] ERR_NONE        = 3'd0;
    localparam logic [2:0] ERR_NOT_WAVE    = 3'd1;
    localparam logic [2:0] ERR_FMT_MISSING = 3'd2;
    localparam logic [2:0] ERR_UNSUPPORTED = 3'd3;
    localparam logic [2:0] ERR_DATA_MISSING = 3'd4;
    localparam logic [2:0] ERR_TOO_LARGE   = 3'd5;

    typedef enum logic [15:0] {
        PH_RIFF         = 16'h0001,
        PH_RIFF_SIZE    = 16'h0002,
        PH_WAVE         = 16'h0004,
        PH_FMT_ID       = 16'h0008,
        PH_FMT_SKIPLEN  = 16'h0010,
        PH_FMT_SKIP     = 16'h0020,
        PH_FMT_LEN      = 16'h0040,
        PH_FMT_BODY     = 16'h0080,
        PH_FMT_EXTRA    = 16'h0100,
        PH_DATA_ID      = 16'h0200,
        PH_DATA_SKIPLEN = 16'h0400,
        PH_DATA_SKIP    = 16'h0800,
        PH_DATA_LEN     = 16'h1000,
        PH_DIV          = 16'h2000,
        PH_PAYLOAD      = 16'h4000,
        PH_WAIT         = 16'h8000
    } phase_t;

endpackage

`default_nettype wire

### rtl/core/wav_header_parser_unit.sv
`default_nettype none

// Channel  | Handshake                    | Beat contents
// ---------+------------------------------+-------------------------------------------
// in       | in_valid / in_ready          | data_byte, stream_end
// out      | out_valid / out_ready        | result_kind, payload_byte, format fields,
//          |                              | error_code, last_payload
// cfg      | cfg_write_en (no wait)       | cfg_write_data -> skip_limit
//
// One byte per cycle for header, skip and payload bytes. The frame-count
// division (data bytes / block align) runs on a radix-2 restoring divider,
// one quotient bit per cycle, once per file after the byte that closes the
// data chunk length, with in_ready low meanwhile.
// A single output register holds each result; in_ready also drops while it
// is full and not being drained, so a stalled consumer stalls the input.
// rst_n (async) returns to the RIFF search and loads skip_limit with 1000.

module wav_header_parser_unit
    import whp_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,

    input  wire logic                 cfg_write_en,
    input  wire logic [HALF_W-1:0]    cfg_write_data,

    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [BYTE_W-1:0]    data_byte,
    input  wire logic                 stream_end,

    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [1:0]                result_kind,
    output logic [BYTE_W-1:0]         payload_byte,
    output logic [1:0]                channel_count,
    output logic [WORD_W-1:0]         sample_rate,
    output logic [5:0]                bits_per_sample,
    output logic [1:0]                sample_kind,
    output logic [ALIGN_W-1:0]        block_align,
    output logic [FRAME_W-1:0]        frame_count,
    output logic [2:0]                error_code,
    output logic                      last_payload
);

    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(FRAME_W - 1);

    // Parser control state
    phase_t               phase_reg, phase_next;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic [HALF_W-1:0]    skips_reg, skips_next;
    logic [HALF_W-1:0]    skip_limit_reg;

    // Parser data state
    logic [WORD_W-1:0]    tag_reg, tag_next;
    logic [WORD_W-1:0]    len_reg, len_next;
    logic [WORD_W-1:0]    skip_rem_reg, skip_rem_next;
    logic [HALF_W-1:0]    ftag_reg, ftag_next;
    logic [HALF_W-1:0]    chan_reg, chan_next;
    logic [WORD_W-1:0]    rate_reg, rate_next;
    logic [HALF_W-1:0]    align_reg, align_next;
    logic [HALF_W-1:0]    bits_reg, bits_next;
    logic [FRAME_W-1:0]   pay_rem_reg, pay_rem_next;

    // Frame-count divider
    logic [ALIGN_W-1:0]   div_rem_reg, div_rem_next;
    logic [FRAME_W-1:0]   div_quo_reg, div_quo_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic [ALIGN_W:0]     div_trial;
    logic [ALIGN_W:0]     div_diff;
    logic                 div_ge;
    logic                 div_done;

    logic                 out_valid_reg;

    logic                 in_fire;
    logic [WORD_W-1:0]    ts;
    logic                 quad_done;
    logic                 fmt_ok;
    logic [HALF_W-1:0]    body_bits;
    logic [HALF_W-1:0]    want_align;
    logic [FRAME_W-1:0]   pay_dec;
    logic                 emit_err;
    logic [2:0]           err_code;
    logic                 emit_pay;
    logic                 pay_last;
    logic                 restart;

    assign in_ready  = (phase_reg != PH_DIV) && (!out_valid_reg || out_ready);
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    assign ts        = {data_byte, tag_reg[WORD_W-1:BYTE_W]};
    assign quad_done = (pos_reg == POS_W'(3));
    assign pay_dec   = pay_rem_reg - FRAME_W'(1);

    // Format check at the last body byte; bits arrive with that byte
    assign body_bits  = ts[WORD_W-1:HALF_W];
    assign want_align = (chan_reg == HALF_W'(2)) ? {body_bits[HALF_W-1:3], 1'b0}
                                                 : {3'b000, body_bits[HALF_W-1:3]};
    assign fmt_ok = (ftag_reg == HALF_W'(1))
                 && (chan_reg == HALF_W'(1) || chan_reg == HALF_W'(2))
                 && (body_bits == HALF_W'(8) || body_bits == HALF_W'(16)
                     || body_bits == HALF_W'(24) || body_bits == HALF_W'(32))
                 && (align_reg == want_align);

    // One restoring step: block align is 1..8 once the format has passed
    assign div_trial = {div_rem_reg, div_quo_reg[FRAME_W-1]};
    assign div_ge    = div_trial >= {1'b0, align_reg[ALIGN_W-1:0]};
    assign div_diff  = div_trial - {1'b0, align_reg[ALIGN_W-1:0]};
    assign div_done  = (phase_reg == PH_DIV) && (div_cnt_reg == DIV_LAST);

    always_comb
    begin
        phase_next    = phase_reg;
        pos_next      = pos_reg;
        skips_next    = skips_reg;
        tag_next      = tag_reg;
        len_next      = len_reg;
        skip_rem_next = skip_rem_reg;
        ftag_next     = ftag_reg;
        chan_next     = chan_reg;
        rate_next     = rate_reg;
        align_next    = align_reg;
        bits_next     = bits_reg;
        pay_rem_next  = pay_rem_reg;
        div_rem_next  = div_rem_reg;
        div_quo_next  = div_quo_reg;
        div_cnt_next  = div_cnt_reg;
        emit_err      = 1'b0;
        err_code      = ERR_NONE;
        emit_pay      = 1'b0;
        pay_last      = 1'b0;
        restart       = 1'b0;

        if (in_fire)
        begin
            tag_next = ts;
            unique case (phase_reg)
                PH_RIFF, PH_WAVE:
                begin
                    if (quad_done)
                    begin
                        pos_next = '0;
                        if (ts != ((phase_reg == PH_RIFF) ? TAG_RIFF : TAG_WAVE))
                        begin
                            emit_err = 1'b1;
                            err_code = ERR_NOT_WAVE;
                        end
                        else
                        begin
                            phase_next = (phase_reg == PH_RIFF) ? PH_RIFF_SIZE : PH_FMT_ID;
                            if (stream_end)
                            begin
                                emit_err = 1'b1;
                                err_code = (phase_reg == PH_RIFF) ? ERR_NOT_WAVE
                                                                  : ERR_FMT_MISSING;
                            end
                        end
                    end
                    else
                    begin
                        pos_next = pos_reg + POS_W'(1);
                        if (stream_end)
                        begin
                            emit_err = 1'b1;
                            err_code = ERR_NOT_WAVE;
                        end
                    end
                end
                PH_RIFF_SIZE:
                begin
                    if (quad_done)
                    begin
                        pos_next   = '0;
                        phase_next = PH_WAVE;
                    end
                    else
                    begin
                        pos_next = pos_reg + POS_W'(1);
                    end
                    if (stream_end)
                    begin
                        emit_err = 1'b1;
                        err_code = ERR_NOT_WAVE;
                    end
                end
                PH_FMT_ID, PH_DATA_ID:
                begin
                    if (quad_done)
                    begin
                        pos_next = '0;
                        if (ts == ((phase_reg == PH_FMT_ID) ? TAG_FMT : TAG_DATA))
                        begin
                            phase_next = (phase_reg == PH_FMT_ID) ? PH_FMT_LEN : PH_DATA_LEN;
                        end
                        else if (skips_reg >= skip_limit_reg)
                        begin
                            emit_err = 1'b1;
                        end
                        else
                        begin
                            skips_next = skips_reg + HALF_W'(1);
                            phase_next = (phase_reg == PH_FMT_ID) ? PH_FMT_SKIPLEN
                                                                  : PH_DATA_SKIPLEN;
                        end
                    end
                    else
                    begin
                        pos_next = pos_reg + POS_W'(1);
                    end
                    if (stream_end)
                    begin
                        emit_err = 1'b1;
                    end
                    err_code = (phase_reg == PH_FMT_ID) ? ERR_FMT_MISSING : ERR_DATA_MISSING;
                end
                PH_FMT_SKIPLEN, PH_DATA_SKIPLEN:
                begin
                    if (quad_done)
                    begin
                        pos_next      = '0;
                        skip_rem_next = ts;
                        if (ts != '0)
                        begin
                            phase_next = (phase_reg == PH_FMT_SKIPLEN) ? PH_FMT_SKIP
                                                                       : PH_DATA_SKIP;
                        end
                        else
                        begin
                            phase_next = (phase_reg == PH_FMT_SKIPLEN) ? PH_FMT_ID
                                                                       : PH_DATA_ID;
                        end
                    end
                    else
                    begin
                        pos_next = pos_reg + POS_W'(1);
                    end
                    emit_err = stream_end;
                    err_code = (phase_reg == PH_FMT_SKIPLEN) ? ERR_FMT_MISSING
                                                             : ERR_DATA_MISSING;
                end
                PH_FMT_SKIP, PH_FMT_EXTRA, PH_DATA_SKIP:
                begin
                    skip_rem_next = skip_rem_reg - WORD_W'(1);
                    if (skip_rem_next == '0)
                    begin
                        phase_next = (phase_reg == PH_FMT_SKIP) ? PH_FMT_ID : PH_DATA_ID;
                    end
                    emit_err = stream_end;
                    err_code = (phase_reg == PH_FMT_SKIP) ? ERR_FMT_MISSING
                                                          : ERR_DATA_MISSING;
                end
                PH_FMT_LEN:
                begin
                    if (quad_done)
                    begin
                        pos_next = '0;
                        len_next = ts;
                        if (ts < PCM_FMT_LEN)
                        begin
                            emit_err = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_FMT_BODY;
                        end
                    end
                    else
                    begin
                        pos_next = pos_reg + POS_W'(1);
                    end
                    if (stream_end)
                    begin
                        emit_err = 1'b1;
                    end
                    err_code = ERR_FMT_MISSING;
                end
                PH_FMT_BODY:
                begin
                    case (pos_reg)
                        POS_W'(1):  ftag_next  = ts[WORD_W-1:HALF_W];
                        POS_W'(3):  chan_next  = ts[WORD_W-1:HALF_W];
                        POS_W'(7):  rate_next  = ts;
                        POS_W'(13): align_next = ts[WORD_W-1:HALF_W];
                        POS_W'(15): bits_next  = ts[WORD_W-1:HALF_W];
                        default:    ;
                    endcase
                    if (pos_reg == POS_W'(15))
                    begin
                        pos_next = '0;
                        if (!fmt_ok)
                        begin
                            emit_err = 1'b1;
                            err_code = ERR_UNSUPPORTED;
                        end
                        else
                        begin
                            skip_rem_next = len_reg - PCM_FMT_LEN;
                            phase_next    = (len_reg != PCM_FMT_LEN) ? PH_FMT_EXTRA
                                                                     : PH_DATA_ID;
                            emit_err      = stream_end;
                            err_code      = ERR_DATA_MISSING;
                        end
                    end
                    else
                    begin
                        pos_next = pos_reg + POS_W'(1);
                        emit_err = stream_end;
                        err_code = ERR_FMT_MISSING;
                    end
                end
                PH_DATA_LEN:
                begin
                    if (quad_done)
                    begin
                        pos_next = '0;
                        len_next = ts;
                        // no whole frame: length below block align
                        if (ts < {{(WORD_W-HALF_W){1'b0}}, align_reg})
                        begin
                            emit_err = 1'b1;
                            err_code = ERR_DATA_MISSING;
                        end
                        else if (ts >= MAX_DATA_BYTES)
                        begin
                            emit_err = 1'b1;
                            err_code = ERR_TOO_LARGE;
                        end
                        else if (stream_end)
                        begin
                            emit_err = 1'b1;
                            err_code = ERR_DATA_MISSING;
                        end
                        else
                        begin
                            phase_next   = PH_DIV;
                            pay_rem_next = ts[FRAME_W-1:0];
                            div_quo_next = ts[FRAME_W-1:0];
                            div_rem_next = '0;
                            div_cnt_next = '0;
                        end
                    end
                    else
                    begin
                        pos_next = pos_reg + POS_W'(1);
                        emit_err = stream_end;
                        err_code = ERR_DATA_MISSING;
                    end
                end
                PH_PAYLOAD:
                begin
                    pay_rem_next = pay_dec;
                    if (pay_dec != '0 && stream_end)
                    begin
                        emit_err = 1'b1;
                        err_code = ERR_DATA_MISSING;
                    end
                    else
                    begin
                        emit_pay = 1'b1;
                        pay_last = (pay_dec == '0);
                        if (pay_dec == '0)
                        begin
                            restart    = stream_end;
                            phase_next = PH_WAIT;
                        end
                    end
                end
                PH_WAIT:
                begin
                    restart = stream_end;
                end
                default:
                begin
                end
            endcase

            if (emit_err)
            begin
                phase_next = PH_WAIT;
                restart    = stream_end;
            end
        end

        if (restart)
        begin
            phase_next = PH_RIFF;
            pos_next   = '0;
            skips_next = '0;
        end

        if (phase_reg == PH_DIV)
        begin
            div_rem_next = div_ge ? div_diff[ALIGN_W-1:0] : div_trial[ALIGN_W-1:0];
            div_quo_next = {div_quo_reg[FRAME_W-2:0], div_ge};
            div_cnt_next = div_cnt_reg + DIV_CNT_W'(1);
            if (div_done)
            begin
                phase_next = PH_PAYLOAD;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_RIFF;
            pos_reg        <= '0;
            skips_reg      <= '0;
            skip_limit_reg <= SKIP_LIMIT_RST;
            div_cnt_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            pos_reg     <= pos_next;
            skips_reg   <= skips_next;
            div_cnt_reg <= div_cnt_next;
            if (cfg_write_en)
            begin
                skip_limit_reg <= cfg_write_data;
            end
            if ((in_fire && (emit_err || emit_pay)) || div_done)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Data registers
    always_ff @(posedge clk)
    begin
        tag_reg      <= tag_next;
        len_reg      <= len_next;
        skip_rem_reg <= skip_rem_next;
        ftag_reg     <= ftag_next;
        chan_reg     <= chan_next;
        rate_reg     <= rate_next;
        align_reg    <= align_next;
        bits_reg     <= bits_next;
        pay_rem_reg  <= pay_rem_next;
        div_rem_reg  <= div_rem_next;
        div_quo_reg  <= div_quo_next;
    end

    // Result register: one beat, all fields rewritten on load
    always_ff @(posedge clk)
    begin
        if ((in_fire && (emit_err || emit_pay)) || div_done)
        begin
            result_kind     <= KIND_REPORT;
            payload_byte    <= '0;
            channel_count   <= '0;
            sample_rate     <= '0;
            bits_per_sample <= '0;
            sample_kind     <= SMP_UNSIGNED;
            block_align     <= '0;
            frame_count     <= '0;
            error_code      <= ERR_NONE;
            last_payload    <= 1'b0;
            if (div_done)
            begin
                channel_count   <= chan_reg[1:0];
                sample_rate     <= rate_reg;
                bits_per_sample <= bits_reg[5:0];
                if (bits_reg == HALF_W'(8))
                begin
                    sample_kind <= SMP_UNSIGNED;
                end
                else if (bits_reg == HALF_W'(32))
                begin
                    sample_kind <= SMP_FLOAT;
                end
                else
                begin
                    sample_kind <= SMP_SIGNED;
                end
                block_align     <= align_reg[ALIGN_W-1:0];
                frame_count     <= div_quo_next;
            end
            else if (emit_err)
            begin
                result_kind <= KIND_ERROR;
                error_code  <= err_code;
            end
            else
            begin
                result_kind  <= KIND_PAYLOAD;
                payload_byte <= data_byte;
                last_payload <= pay_last;
            end
        end
    end

endmodule

`default_nettype wire
